/* sv/button_click_dimmer_controller_assert.svh */
// assertion macros for the button click dimmer controller
// used by the top level; no other dependencies
`ifndef BUTTON_CLICK_DIMMER_CONTROLLER_ASSERT_SVH
`define BUTTON_CLICK_DIMMER_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcd assertion failed");

`define BCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcd assertion failed");

`else

`define BCD_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define BCD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/bcd_pkg.sv */
// shared types, codes and constants of the button click dimmer controller
// no dependencies
package bcd_pkg;

  localparam int PWM_BITS = 8;

  localparam int WINDOW_W = 8;
  localparam int LIMIT_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DUTY_W   = 8;

  localparam logic [7:0] BRIGHT_MAX   = 8'd254;
  localparam logic [7:0] BRIGHT_MIN   = 8'd1;
  localparam logic [7:0] BRIGHT_RESET = 8'd127;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd30;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd1000;
  localparam logic [LIMIT_W-1:0]  COUNT_SAT_EDGE = 16'd65533;
  localparam logic [LIMIT_W-1:0]  COUNT_MAX    = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'd1;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_HOLD    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OFF_NONE     = 2'd0,
    OFF_BATTERY  = 2'd1,
    OFF_OVERHEAT = 2'd2
  } off_reason_t;

  typedef enum logic [2:0] {
    STEP_IDLE = 3'b001,
    STEP_ONE  = 3'b010,
    STEP_TWO  = 3'b100
  } step_t;

  typedef struct packed {
    step_t            click_step;
    logic [7:0]       click_timer;
    logic             hold_active;
    logic             dim_upward;
    logic [7:0]       brightness;
    logic             lamp_state;
    logic [15:0]      press_counter;
  } state_t;

  typedef struct packed {
    logic              led_on;
    logic [DUTY_W-1:0] pwm_duty;
    logic              click_request;
    logic              force_off;
    logic              reset_request;
    logic [1:0]        off_reason;
  } result_t;

  function automatic logic [DUTY_W-1:0] duty_of(input logic on, input logic [7:0] level);
    logic [15:0] mask;
    mask = 16'((32'd1 << PWM_BITS) - 32'd1);
    duty_of = on ? DUTY_W'(16'(level) & mask) : '0;
  endfunction

endpackage

/* sv/bcd_if.sv */
// handshake channels of the button click dimmer controller
// depends on bcd_pkg
interface bcd_key_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       battery_low;
  logic       overheated;
  modport source (output valid, action, battery_low, overheated, input ready);
  modport sink (input valid, action, battery_low, overheated, output ready);
endinterface

interface bcd_lamp_if;
  logic                      valid;
  logic                      ready;
  logic                      led_on;
  logic [bcd_pkg::DUTY_W-1:0] pwm_duty;
  logic                      click_request;
  logic                      force_off;
  logic                      reset_request;
  logic [1:0]                off_reason;
  modport source (output valid, led_on, pwm_duty, click_request, force_off,
                  reset_request, off_reason, input ready);
  modport sink (input valid, led_on, pwm_duty, click_request, force_off,
                reset_request, off_reason, output ready);
endinterface

interface bcd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bcd_pkg::CFG_IDX_W-1:0]  index;
  logic [bcd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/bcd_tick.sv */
// next-state and result logic for one tick of the dimmer controller
// depends on bcd_pkg
module bcd_tick (
  input  bcd_pkg::state_t                   state,
  input  logic [1:0]                        action,
  input  logic                              battery_low,
  input  logic                              overheated,
  input  logic [bcd_pkg::WINDOW_W-1:0]      window,
  input  logic [bcd_pkg::LIMIT_W-1:0]       limit,
  output bcd_pkg::state_t                   state_next,
  output bcd_pkg::result_t                  result
);

  bcd_pkg::action_t     act;
  bcd_pkg::step_t       step;
  logic [7:0]           timer;
  logic                 hold;
  logic                 upward;
  logic                 lamp;
  logic [7:0]           level;
  logic [15:0]          count;
  logic                 click_req;
  logic                 cut_req;
  logic                 rst_req;
  bcd_pkg::off_reason_t reason;

  assign act = bcd_pkg::action_t'(action);

  always_comb begin
    step = state.click_step;
    timer = state.click_timer;
    hold = state.hold_active;
    upward = state.dim_upward;
    lamp = state.lamp_state;
    level = state.brightness;
    count = state.press_counter;
    click_req = 1'b0;
    cut_req = 1'b0;
    rst_req = 1'b0;
    reason = bcd_pkg::OFF_NONE;

    // window countdown
    if (timer != 8'd0) begin
      timer = timer - 8'd1;
    end else begin
      step = bcd_pkg::STEP_IDLE;
    end

    unique case (act)
      bcd_pkg::ACT_PRESS: begin
        unique case (step)
          bcd_pkg::STEP_IDLE: begin
            timer = window;
            step = bcd_pkg::STEP_ONE;
            click_req = 1'b1;
          end
          bcd_pkg::STEP_ONE: begin
            timer = window;
            step = bcd_pkg::STEP_TWO;
          end
          default: begin
            step = bcd_pkg::STEP_IDLE;
          end
        endcase
      end
      bcd_pkg::ACT_RELEASE: begin
        unique case (step)
          bcd_pkg::STEP_ONE: begin
            timer = window;
          end
          bcd_pkg::STEP_TWO: begin
            timer = 8'd0;
            lamp = !lamp;
          end
          default: begin
            step = bcd_pkg::STEP_IDLE;
          end
        endcase
        hold = 1'b0;
      end
      bcd_pkg::ACT_HOLD: begin
        hold = 1'b1;
        if (lamp) begin
          upward = !upward;
        end else begin
          cut_req = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // fault cut-off, low battery first
    if (lamp && battery_low) begin
      lamp = 1'b0;
      reason = bcd_pkg::OFF_BATTERY;
    end else if (lamp && overheated) begin
      lamp = 1'b0;
      reason = bcd_pkg::OFF_OVERHEAT;
    end

    priority if (lamp && hold) begin
      if (upward && level < bcd_pkg::BRIGHT_MAX) begin
        level = level + 8'd1;
      end else if (!upward && level > bcd_pkg::BRIGHT_MIN) begin
        level = level - 8'd1;
      end
    end else if (hold) begin
      if (count > bcd_pkg::COUNT_SAT_EDGE) begin
        count = bcd_pkg::COUNT_MAX;
      end else begin
        count = count + 16'd2;
      end
      rst_req = count > limit;
    end else begin
      count = 16'd0;
    end

    state_next.click_step = step;
    state_next.click_timer = timer;
    state_next.hold_active = hold;
    state_next.dim_upward = upward;
    state_next.brightness = level;
    state_next.lamp_state = lamp;
    state_next.press_counter = count;

    result.led_on = lamp;
    result.pwm_duty = bcd_pkg::duty_of(lamp, level);
    result.click_request = click_req;
    result.force_off = cut_req;
    result.reset_request = rst_req;
    result.off_reason = reason;
  end

endmodule

/* sv/button_click_dimmer_controller.sv */
// Button click dimmer controller: one key item per tick in, one lamp result out.
// Each accepted item passes through the combinational tick logic and its result is
// held in an output register; a new item is accepted every cycle the output register is
// empty or being drained, so throughput is one item per clock.
// Configuration writes (double-click window, reset press limit) are taken at any time.
// Depends on bcd_pkg, bcd_if, bcd_tick and button_click_dimmer_controller_assert.svh.
`include "button_click_dimmer_controller_assert.svh"

module button_click_dimmer_controller (
  input logic         clk,
  input logic         rst,
  bcd_cfg_if.sink     cfg,
  bcd_key_if.sink     key,
  bcd_lamp_if.source  lamp
);

  bcd_pkg::state_t                 state;
  bcd_pkg::state_t                 state_next;
  bcd_pkg::result_t                result;
  bcd_pkg::result_t                result_next;
  logic                            out_valid;
  logic [bcd_pkg::WINDOW_W-1:0]    window;
  logic [bcd_pkg::LIMIT_W-1:0]     limit;
  logic                            accept;

  assign cfg.ready = 1'b1;
  assign key.ready = !out_valid || lamp.ready;
  assign accept = key.valid && key.ready;

  bcd_tick u_tick (
    .state       (state),
    .action      (key.action),
    .battery_low (key.battery_low),
    .overheated  (key.overheated),
    .window      (window),
    .limit       (limit),
    .state_next  (state_next),
    .result      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= bcd_pkg::WINDOW_RESET;
      limit <= bcd_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bcd_pkg::REG_WINDOW: window <= cfg.data[bcd_pkg::WINDOW_W-1:0];
        bcd_pkg::REG_LIMIT:  limit <= cfg.data[bcd_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.click_step <= bcd_pkg::STEP_IDLE;
      state.click_timer <= 8'd0;
      state.hold_active <= 1'b0;
      state.dim_upward <= 1'b1;
      state.brightness <= bcd_pkg::BRIGHT_RESET;
      state.lamp_state <= 1'b0;
      state.press_counter <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
        out_valid <= 1'b1;
      end else if (lamp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign lamp.valid = out_valid;
  assign lamp.led_on = result.led_on;
  assign lamp.pwm_duty = result.pwm_duty;
  assign lamp.click_request = result.click_request;
  assign lamp.force_off = result.force_off;
  assign lamp.reset_request = result.reset_request;
  assign lamp.off_reason = result.off_reason;

  `BCD_ASSERT_NXT(a_accept_gives_result, clk, rst, accept, out_valid)
  `BCD_ASSERT_IMP(a_off_no_duty, clk, rst, out_valid && !result.led_on, result.pwm_duty == '0)
  `BCD_ASSERT_IMP(a_force_lamp_off, clk, rst, out_valid && result.force_off, !result.led_on)
  `BCD_ASSERT_IMP(a_reason_lamp_off, clk, rst, out_valid && result.off_reason != bcd_pkg::OFF_NONE,
                  !result.led_on)
  `BCD_ASSERT_IMP(a_bright_range, clk, rst, 1'b1,
                  state.brightness >= bcd_pkg::BRIGHT_MIN &&
                  state.brightness <= bcd_pkg::BRIGHT_MAX)

endmodule

/* bench/button_click_dimmer_controller_tb.sv */
`timescale 1ns / 1ps
// testbench for button_click_dimmer_controller: directed and random key items, each
// lamp item checked against a tick predictor; depends on bcd_pkg, bcd_if and the rtl
module button_click_dimmer_controller_tb;

  localparam int CYCLE_LIMIT    = 1500000;
  localparam int HOLDOFF_CYCLES = 64;
  localparam int MAX_REPORTS    = 30;
  localparam int FAULT_ODDS     = 40;

  localparam logic [7:0]  LEVEL_TOP    = 8'd254;
  localparam logic [7:0]  LEVEL_BOTTOM = 8'd1;
  localparam logic [7:0]  LEVEL_START  = 8'd127;
  localparam logic [7:0]  WINDOW_START = 8'd30;
  localparam logic [15:0] LIMIT_START  = 16'd1000;
  localparam logic [15:0] PRESS_NEAR_FULL = 16'd65533;
  localparam logic [15:0] PRESS_FULL   = 16'hFFFF;

  typedef enum logic [1:0] {CLICK_IDLE, CLICK_FIRST, CLICK_SECOND} click_phase_t;

  class dimmer_scoreboard;
    click_phase_t phase;
    logic [7:0]   timer;
    logic [7:0]   window;
    logic [7:0]   level;
    logic [15:0]  presses;
    logic [15:0]  limit;
    bit           holding;
    bit           ramp_up;
    bit           lamp;
    bcd_pkg::result_t expected_lamp[$];
    int           errors, checked, wakes, cutoffs, resets, fault_offs;

    function new();
      phase = CLICK_IDLE;
      timer = '0;
      window = WINDOW_START;
      limit = LIMIT_START;
      level = LEVEL_START;
      presses = '0;
      holding = 1'b0;
      ramp_up = 1'b1;
      lamp = 1'b0;
    endfunction

    function void set_reg(logic [bcd_pkg::CFG_IDX_W-1:0] idx,
                          logic [bcd_pkg::CFG_DATA_W-1:0] data);
      if (idx == bcd_pkg::REG_WINDOW) window = data[7:0];
      else if (idx == bcd_pkg::REG_LIMIT) limit = data[15:0];
    endfunction

    function void note_key(bcd_pkg::action_t act, logic low_bat, logic hot);
      bcd_pkg::result_t r;
      r = '0;
      if (timer != 0) timer--;
      else phase = CLICK_IDLE;
      case (act)
        bcd_pkg::ACT_PRESS: begin
          if (phase == CLICK_IDLE) begin
            timer = window;
            phase = CLICK_FIRST;
            r.click_request = 1'b1;
          end else if (phase == CLICK_FIRST) begin
            timer = window;
            phase = CLICK_SECOND;
          end else begin
            phase = CLICK_IDLE;
          end
        end
        bcd_pkg::ACT_RELEASE: begin
          if (phase == CLICK_FIRST) begin
            timer = window;
          end else if (phase == CLICK_SECOND) begin
            timer = '0;
            lamp = !lamp;
          end
          holding = 1'b0;
        end
        bcd_pkg::ACT_HOLD: begin
          holding = 1'b1;
          if (lamp) ramp_up = !ramp_up;
          else r.force_off = 1'b1;
        end
        default: ;
      endcase
      if (lamp && low_bat) begin
        lamp = 1'b0;
        r.off_reason = bcd_pkg::OFF_BATTERY;
      end else if (lamp && hot) begin
        lamp = 1'b0;
        r.off_reason = bcd_pkg::OFF_OVERHEAT;
      end
      if (lamp && holding) begin
        if (ramp_up && level < LEVEL_TOP) level++;
        else if (!ramp_up && level > LEVEL_BOTTOM) level--;
      end else if (holding) begin
        presses = (presses > PRESS_NEAR_FULL) ? PRESS_FULL : presses + 16'd2;
        r.reset_request = (presses > limit);
      end else begin
        presses = '0;
      end
      r.led_on = lamp;
      r.pwm_duty = lamp ? level : '0;
      wakes += r.click_request;
      cutoffs += r.force_off;
      resets += r.reset_request;
      fault_offs += (r.off_reason != bcd_pkg::OFF_NONE);
      expected_lamp.push_back(r);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
    endfunction

    function void compare(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("lamp item %0d %s got %0h want %0h", checked, name, got, want));
    endfunction

    function void check_lamp(bcd_pkg::result_t got);
      bcd_pkg::result_t want;
      if (expected_lamp.size() == 0) begin
        report("lamp item with nothing expected");
        return;
      end
      want = expected_lamp.pop_front();
      compare("led_on", 16'(got.led_on), 16'(want.led_on));
      compare("pwm_duty", 16'(got.pwm_duty), 16'(want.pwm_duty));
      compare("click_request", 16'(got.click_request), 16'(want.click_request));
      compare("force_off", 16'(got.force_off), 16'(want.force_off));
      compare("reset_request", 16'(got.reset_request), 16'(want.reset_request));
      compare("off_reason", 16'(got.off_reason), 16'(want.off_reason));
      checked++;
    endfunction

    function void finish_check();
      if (expected_lamp.size() != 0)
        report($sformatf("%0d lamp items never came", expected_lamp.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcd_key_if  key ();
  bcd_lamp_if lamp ();
  bcd_cfg_if  cfg ();

  button_click_dimmer_controller u_top (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .key  (key),
    .lamp (lamp)
  );

  dimmer_scoreboard sb = new();

  int burst_left = 0;
  int items_sent = 0;
  int fault_odds = FAULT_ODDS;
  int cfg_writes = 0;
  int holdoff_req = 0;
  int holdoffs_served = 0;
  int holdoff_left = 0;
  int ready_mode = 0;
  int ready_mode_left = 0;
  int unsigned cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("button_click_dimmer_controller_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    bcd_pkg::result_t got;
    if (!rst && lamp.valid && lamp.ready) begin
      got.led_on = lamp.led_on;
      got.pwm_duty = lamp.pwm_duty;
      got.click_request = lamp.click_request;
      got.force_off = lamp.force_off;
      got.reset_request = lamp.reset_request;
      got.off_reason = lamp.off_reason;
      sb.check_lamp(got);
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      lamp.ready <= 1'b0;
    end else if (holdoffs_served != holdoff_req) begin
      holdoffs_served++;
      holdoff_left = HOLDOFF_CYCLES;
      lamp.ready <= 1'b0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        ready_mode_left = $urandom_range(16, 160);
      end
      ready_mode_left--;
      case (ready_mode)
        0: lamp.ready <= 1'b1;
        1: lamp.ready <= ($urandom_range(0, 3) != 0);
        default: lamp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic fault_roll();
    return fault_odds != 0 && $urandom_range(1, fault_odds) == 1;
  endfunction

  task automatic send_key(bcd_pkg::action_t act, logic low_bat, logic hot);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        key.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    key.valid <= 1'b1;
    key.action <= act;
    key.battery_low <= low_bat;
    key.overheated <= hot;
    @(posedge clk);
    while (!key.ready) @(posedge clk);
    sb.note_key(act, low_bat, hot);
    burst_left--;
    items_sent++;
  endtask

  task automatic tick(bcd_pkg::action_t act);
    send_key(act, fault_roll(), fault_roll());
  endtask

  task automatic idle_ticks(int n);
    repeat (n) tick(bcd_pkg::ACT_NONE);
  endtask

  // stop offering items until every lamp item is back through the output register
  task automatic drain();
    key.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_lamp.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [bcd_pkg::CFG_IDX_W-1:0] idx,
                           logic [bcd_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic configure(logic [7:0] win, logic [15:0] lim);
    drain();
    write_reg(bcd_pkg::REG_WINDOW, {8'($urandom), win});
    write_reg(bcd_pkg::REG_LIMIT, lim);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int start;
    int len;
    start = items_sent;
    while (items_sent - start < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          tick(bcd_pkg::ACT_PRESS);
          idle_ticks($urandom_range(0, 3));
          tick(bcd_pkg::ACT_RELEASE);
          idle_ticks($urandom_range(0, 3));
          tick(bcd_pkg::ACT_PRESS);
          idle_ticks($urandom_range(0, 3));
          tick(bcd_pkg::ACT_RELEASE);
        end
        3, 4: begin
          // long holds run the ramp into its limits
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(130, 260) : $urandom_range(0, 30);
          if (len > 100) fault_odds = 0;
          tick(bcd_pkg::ACT_PRESS);
          tick(bcd_pkg::ACT_HOLD);
          idle_ticks(len);
          tick(bcd_pkg::ACT_RELEASE);
          fault_odds = FAULT_ODDS;
        end
        5: begin
          tick(bcd_pkg::ACT_PRESS);
          idle_ticks($urandom_range(0, 2));
          tick(bcd_pkg::ACT_RELEASE);
        end
        6: repeat ($urandom_range(3, 5)) tick(bcd_pkg::ACT_PRESS);
        7: repeat ($urandom_range(1, 6)) tick(bcd_pkg::action_t'($urandom_range(0, 3)));
        8: idle_ticks($urandom_range(0, 40));
        default: begin
          fault_odds = 2;
          repeat ($urandom_range(1, 4)) tick(bcd_pkg::action_t'($urandom_range(0, 3)));
          fault_odds = FAULT_ODDS;
        end
      endcase
    end
  endtask

  initial begin
    key.valid <= 1'b0;
    key.action <= bcd_pkg::ACT_NONE;
    key.battery_low <= 1'b0;
    key.overheated <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= bcd_pkg::REG_WINDOW;
    cfg.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // stray release, faults while off, hold with the lamp off
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_NONE, 1'b1, 1'b1);
    send_key(bcd_pkg::ACT_HOLD, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_NONE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    // double click on, dim down then up
    send_key(bcd_pkg::ACT_PRESS, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_PRESS, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_HOLD, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_NONE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_HOLD, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    // third press ends the sequence
    repeat (4) send_key(bcd_pkg::ACT_PRESS, 1'b0, 1'b0);
    // both faults, then overheat alone
    send_key(bcd_pkg::ACT_NONE, 1'b1, 1'b1);
    send_key(bcd_pkg::ACT_PRESS, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_NONE, 1'b0, 1'b1);
    // zero window and zero limit
    configure(8'd0, 16'd0);
    send_key(bcd_pkg::ACT_HOLD, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_PRESS, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_PRESS, 1'b0, 1'b0);

    // long press counter crosses its limit, receiver holds off meanwhile
    configure(WINDOW_START, 16'd100);
    fault_odds = 0;
    send_key(bcd_pkg::ACT_NONE, 1'b1, 1'b0);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    send_key(bcd_pkg::ACT_HOLD, 1'b0, 1'b0);
    holdoff_req <= holdoff_req + 1;
    idle_ticks(80);
    configure(WINDOW_START, LIMIT_START);
    idle_ticks(3);
    send_key(bcd_pkg::ACT_RELEASE, 1'b0, 1'b0);
    fault_odds = FAULT_ODDS;

    configure(8'd1, 16'd0);
    random_phase(120);
    configure(8'd255, PRESS_FULL);
    random_phase(120);
    configure(8'd8, 16'd60);
    random_phase(60);
    drain();
    random_phase(60);
    configure(8'd0, 16'd10);
    random_phase(100);
    configure(8'd3, 16'd20);
    random_phase(100);
    configure(8'd100, 16'd300);
    random_phase(100);

    drain();
    sb.finish_check();
    $display("summary: %0d key items sent, %0d lamp items checked, %0d register writes",
             items_sent, sb.checked, cfg_writes);
    $display("summary: %0d click wakes, %0d cut-offs, %0d reset requests, %0d fault offs",
             sb.wakes, sb.cutoffs, sb.resets, sb.fault_offs);
    if (sb.errors == 0) begin
      $display("button_click_dimmer_controller_tb: done, clean");
    end else begin
      $display("button_click_dimmer_controller_tb: done, errors");
    end
    $finish;
  end

endmodule

/* button_click_dimmer_controller.f */
+incdir+sv
sv/bcd_pkg.sv
sv/bcd_if.sv
sv/bcd_tick.sv
sv/button_click_dimmer_controller.sv
bench/button_click_dimmer_controller_tb.sv
